### rtl/core/cbq_pkg.sv
// ----------------------------------------------------------------------------
// cbq_pkg: shared types and constants of the cascaded biquad low-pass filter
// Number formats, register indexes, sequencer states and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cbq_pkg;

	// Field and format widths
	localparam int MAX_BIQUADS = 5;
	localparam int SAMPLE_W    = 24;
	localparam int COEF_W      = 20;
	localparam int COEF_FRAC   = COEF_W - 2;
	localparam int STATE_W     = 48;
	localparam int STATE_FRAC  = 8;
	localparam int COUNT_W     = 3;
	localparam int CFG_W       = 3 * COEF_W;
	localparam int CFG_IDX_W   = 3;

	// Section indexes: biquads 0..MAX_BIQUADS-1, the one-pole section last
	localparam int SEC_W    = $clog2(MAX_BIQUADS + 1);
	localparam int BQ_IDX_W = $clog2(MAX_BIQUADS);
	localparam logic [SEC_W-1:0] POLE_SEC = SEC_W'(MAX_BIQUADS);

	// Multiply operand: m + 2*z1 + z2 needs two guard bits plus sign
	localparam int OPND_W = STATE_W + 3;
	localparam int LO_W   = 24;
	localparam int HALF_W = OPND_W - LO_W + 1;
	localparam int PROD_W = HALF_W + COEF_W;
	localparam int ACC_W  = PROD_W + LO_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIQUAD_COUNT = 3'd0,
		CFG_POLE_ON      = 3'd1,
		CFG_POLE_COEFS   = 3'd2,
		CFG_BQ0          = 3'd3,
		CFG_BQ1          = 3'd4,
		CFG_BQ2          = 3'd5,
		CFG_BQ3          = 3'd6,
		CFG_BQ4          = 3'd7
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEC_LOAD,
		ST_FB,
		ST_ROUND_M,
		ST_SUM,
		ST_FF,
		ST_ROUND_V,
		ST_FINISH
	} state_t;

	// Product select of the shared multiplier
	typedef enum logic [1:0] {
		MUL_A1Z1,
		MUL_A2Z2,
		MUL_GS
	} mul_sel_t;

	// Accumulator operation on the registered product
	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_SUB_LO,
		ACC_SUB_HI,
		ACC_SET_LO,
		ACC_ADD_HI
	} acc_op_t;

	typedef struct packed {
		logic             load_x;
		logic             sec_load;
		logic             mul_en;
		mul_sel_t         mul_sel;
		logic             mul_hi;
		acc_op_t          acc_op;
		logic             round_m;
		logic             sum;
		logic             round_v;
		logic             out_load;
		logic [SEC_W-1:0] sec;
		logic             is_pole;
	} cmd_t;

	typedef struct packed {
		logic               pole_on;
		logic [COUNT_W-1:0] count;
	} status_t;

endpackage

### rtl/core/cbq_datapath.sv
// ----------------------------------------------------------------------------
// cbq_datapath: arithmetic and storage of the cascaded biquad filter
// Holds configuration, section states and one shared 28x20 multiplier with a
// wide accumulator, rounding and saturation, all driven by controller commands.
// ----------------------------------------------------------------------------
module cbq_datapath
	import cbq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [SAMPLE_W-1:0]  sample_in,
	output logic [SAMPLE_W-1:0]  sample_out,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers
	logic [COUNT_W-1:0]       biquad_count_q;
	logic                     pole_on_q;
	logic signed [COEF_W-1:0] pole_a1_q, pole_g_q;
	logic signed [COEF_W-1:0] bq_a1_q [MAX_BIQUADS];
	logic signed [COEF_W-1:0] bq_a2_q [MAX_BIQUADS];
	logic signed [COEF_W-1:0] bq_g_q  [MAX_BIQUADS];

	// Section state
	logic signed [STATE_W-1:0] delay_one_q [MAX_BIQUADS+1];
	logic signed [STATE_W-1:0] delay_two_q [MAX_BIQUADS];

	// Working registers
	logic signed [STATE_W-1:0] v_q, m_q, z1_q, z2_q;
	logic signed [OPND_W-1:0]  s_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  prod_s1;
	logic [SAMPLE_W-1:0]       out_q;

	logic [BQ_IDX_W-1:0]       bi;
	logic [BQ_IDX_W-1:0]       cfg_slot;
	logic signed [COEF_W-1:0]  a1, a2, g, coef;
	logic signed [OPND_W-1:0]  opnd;
	logic signed [HALF_W-1:0]  half;
	logic signed [ACC_W-1:0]   prod_lo, prod_hi;
	logic signed [ACC_W-1:0]   rnd_m;
	logic [ACC_W-COEF_FRAC-1:0] sh_m;
	logic signed [STATE_W-1:0] sat_m;
	logic signed [OPND_W-1:0]  sum_next;
	logic signed [STATE_W:0]   rnd_out;
	logic [STATE_W-STATE_FRAC:0] sh_out;
	logic [SAMPLE_W-1:0]       sat_out;

	// Status: pole enable and the biquad count clamped to MAX_BIQUADS
	always_comb begin
		status.pole_on = pole_on_q;
		if (biquad_count_q > COUNT_W'(MAX_BIQUADS)) begin
			status.count = COUNT_W'(MAX_BIQUADS);
		end else begin
			status.count = biquad_count_q;
		end
	end

	// Configuration writes
	assign cfg_slot = BQ_IDX_W'(cfg_index - CFG_BQ0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biquad_count_q <= '0;
			pole_on_q      <= 1'b0;
			pole_a1_q      <= '0;
			pole_g_q       <= '0;
			for (int i = 0; i < MAX_BIQUADS; i++) begin
				bq_a1_q[i] <= '0;
				bq_a2_q[i] <= '0;
				bq_g_q[i]  <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIQUAD_COUNT: biquad_count_q <= cfg_data[COUNT_W-1:0];
				CFG_POLE_ON:      pole_on_q <= cfg_data[0];
				CFG_POLE_COEFS: begin
					pole_a1_q <= cfg_data[COEF_W-1:0];
					pole_g_q  <= cfg_data[2*COEF_W-1:COEF_W];
				end
				default: begin
					bq_a1_q[cfg_slot] <= cfg_data[COEF_W-1:0];
					bq_a2_q[cfg_slot] <= cfg_data[2*COEF_W-1:COEF_W];
					bq_g_q[cfg_slot]  <= cfg_data[3*COEF_W-1:2*COEF_W];
				end
			endcase
		end
	end

	// Coefficients of the current section
	assign bi = cmd.is_pole ? '0 : BQ_IDX_W'(cmd.sec);

	always_comb begin
		if (cmd.is_pole) begin
			a1 = pole_a1_q;
			a2 = '0;
			g  = pole_g_q;
		end else begin
			a1 = bq_a1_q[bi];
			a2 = bq_a2_q[bi];
			g  = bq_g_q[bi];
		end
	end

	// Multiplier operand and half select: signed high half, unsigned low half
	always_comb begin
		case (cmd.mul_sel)
			MUL_A1Z1: begin
				opnd = OPND_W'(z1_q);
				coef = a1;
			end
			MUL_A2Z2: begin
				opnd = OPND_W'(z2_q);
				coef = a2;
			end
			default: begin
				opnd = s_q;
				coef = g;
			end
		endcase
		if (cmd.mul_hi) begin
			half = HALF_W'($signed(opnd[OPND_W-1:LO_W]));
		end else begin
			half = {{(HALF_W-LO_W){1'b0}}, opnd[LO_W-1:0]};
		end
	end

	// Align the registered product for the low or high half
	assign prod_lo = ACC_W'(prod_s1);
	assign prod_hi = {prod_s1, {LO_W{1'b0}}};

	// Round the accumulator by the coefficient fraction and saturate
	assign rnd_m = acc_q + (ACC_W'(1) <<< (COEF_FRAC - 1));
	assign sh_m  = rnd_m[ACC_W-1:COEF_FRAC];

	always_comb begin
		if (sh_m[ACC_W-COEF_FRAC-1:STATE_W-1] == {(ACC_W-COEF_FRAC-STATE_W+1){sh_m[STATE_W-1]}})
		begin
			sat_m = sh_m[STATE_W-1:0];
		end else if (sh_m[ACC_W-COEF_FRAC-1]) begin
			sat_m = {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			sat_m = {1'b0, {(STATE_W-1){1'b1}}};
		end
	end

	// Feed-forward sum: m + 2*z1 + z2 for a biquad, m + z1 for the one-pole
	always_comb begin
		sum_next = OPND_W'(m_q) + OPND_W'(z1_q) + OPND_W'(z2_q);
		if (!cmd.is_pole) begin
			sum_next = sum_next + OPND_W'(z1_q);
		end
	end

	// Final value: round off the state fraction and saturate to a sample
	assign rnd_out = {v_q[STATE_W-1], v_q} + ((STATE_W+1)'(1) <<< (STATE_FRAC - 1));
	assign sh_out  = rnd_out[STATE_W:STATE_FRAC];

	always_comb begin
		if (sh_out[STATE_W-STATE_FRAC:SAMPLE_W-1] ==
			{(STATE_W-STATE_FRAC-SAMPLE_W+2){sh_out[SAMPLE_W-1]}}) begin
			sat_out = sh_out[SAMPLE_W-1:0];
		end else if (sh_out[STATE_W-STATE_FRAC]) begin
			sat_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			sat_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	// Working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			v_q <= {{(STATE_W-SAMPLE_W-STATE_FRAC){sample_in[SAMPLE_W-1]}}, sample_in,
				{STATE_FRAC{1'b0}}};
		end
		if (cmd.sec_load) begin
			z1_q  <= delay_one_q[cmd.sec];
			z2_q  <= cmd.is_pole ? '0 : delay_two_q[bi];
			acc_q <= {{(ACC_W-STATE_W-COEF_FRAC){v_q[STATE_W-1]}}, v_q, {COEF_FRAC{1'b0}}};
		end
		if (cmd.mul_en) begin
			prod_s1 <= half * coef;
		end
		case (cmd.acc_op)
			ACC_SUB_LO: acc_q <= acc_q - prod_lo;
			ACC_SUB_HI: acc_q <= acc_q - prod_hi;
			ACC_SET_LO: acc_q <= prod_lo;
			ACC_ADD_HI: acc_q <= acc_q + prod_hi;
			default: ;
		endcase
		if (cmd.round_m) begin
			m_q <= sat_m;
		end
		if (cmd.sum) begin
			s_q <= sum_next;
		end
		if (cmd.round_v) begin
			v_q <= sat_m;
		end
		if (cmd.out_load) begin
			out_q <= sat_out;
		end
	end

	// Section state update at the end of each section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= MAX_BIQUADS; i++) begin
				delay_one_q[i] <= '0;
			end
			for (int i = 0; i < MAX_BIQUADS; i++) begin
				delay_two_q[i] <= '0;
			end
		end else if (cmd.round_v) begin
			delay_one_q[cmd.sec] <= m_q;
			if (!cmd.is_pole) begin
				delay_two_q[bi] <= z1_q;
			end
		end
	end

	assign sample_out = out_q;

endmodule

### rtl/core/cbq_ctrl.sv
// ----------------------------------------------------------------------------
// cbq_ctrl: sequencer of the cascaded biquad filter
// Steps through the active sections for one sample, issues multiply and
// accumulate commands and owns the output valid flag.
// ----------------------------------------------------------------------------
module cbq_ctrl
	import cbq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t           state_q, state_d;
	logic [2:0]       step_q;
	logic [SEC_W-1:0] sec_q;
	logic             pole_q;
	logic             out_valid_q;
	logic             more_sec;
	logic             out_free;

	// Another section follows the current one
	always_comb begin
		if (pole_q) begin
			more_sec = (status.count != '0);
		end else begin
			more_sec = (COUNT_W'(sec_q + SEC_W'(1)) < status.count);
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (status.pole_on || status.count != '0) begin
						state_d = ST_SEC_LOAD;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SEC_LOAD: state_d = ST_FB;
			ST_FB:       if (step_q == 3'd4) state_d = ST_ROUND_M;
			ST_ROUND_M:  state_d = ST_SUM;
			ST_SUM:      state_d = ST_FF;
			ST_FF:       if (step_q == 3'd2) state_d = ST_ROUND_V;
			ST_ROUND_V:  state_d = more_sec ? ST_SEC_LOAD : ST_FINISH;
			ST_FINISH:   if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_A1Z1;
		cmd.acc_op  = ACC_NONE;
		cmd.sec     = sec_q;
		cmd.is_pole = pole_q;
		case (state_q)
			ST_IDLE:     cmd.load_x = in_valid;
			ST_SEC_LOAD: cmd.sec_load = 1'b1;
			ST_FB: begin
				case (step_q)
					3'd0: begin
						cmd.mul_en = 1'b1;
					end
					3'd1: begin
						cmd.mul_en = 1'b1;
						cmd.mul_hi = 1'b1;
						cmd.acc_op = ACC_SUB_LO;
					end
					3'd2: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = MUL_A2Z2;
						cmd.acc_op  = ACC_SUB_HI;
					end
					3'd3: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = MUL_A2Z2;
						cmd.mul_hi  = 1'b1;
						cmd.acc_op  = ACC_SUB_LO;
					end
					default: cmd.acc_op = ACC_SUB_HI;
				endcase
			end
			ST_ROUND_M: cmd.round_m = 1'b1;
			ST_SUM:     cmd.sum = 1'b1;
			ST_FF: begin
				cmd.mul_sel = MUL_GS;
				case (step_q)
					3'd0: cmd.mul_en = 1'b1;
					3'd1: begin
						cmd.mul_en = 1'b1;
						cmd.mul_hi = 1'b1;
						cmd.acc_op = ACC_SET_LO;
					end
					default: cmd.acc_op = ACC_ADD_HI;
				endcase
			end
			ST_ROUND_V: cmd.round_v = 1'b1;
			ST_FINISH:  cmd.out_load = out_free;
			default: ;
		endcase
	end

	// State, step counter and section pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			sec_q       <= '0;
			pole_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d == state_q) ? step_q + 3'd1 : 3'd0;

			// Pick the first section on a new transaction
			if (state_q == ST_IDLE && in_valid) begin
				pole_q <= status.pole_on;
				sec_q  <= status.pole_on ? POLE_SEC : '0;
			end

			// Advance to the next biquad
			if (state_q == ST_ROUND_V && more_sec) begin
				pole_q <= 1'b0;
				sec_q  <= pole_q ? '0 : sec_q + SEC_W'(1);
			end

			// Hold the result until the output transaction completes
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### rtl/core/cascaded_biquad_lowpass_filter.sv
// ----------------------------------------------------------------------------
// cascaded_biquad_lowpass_filter: top level of the cascaded biquad filter
// One signed 24-bit sample in, one filtered and saturated sample out.
// ----------------------------------------------------------------------------
// Each input transaction runs an optional one-pole section and then up to five
// direct-form-II biquads, all on one shared 28x20 multiplier that forms each
// 48-bit state product as two partial products. Every active section runs
// the state load, five feedback steps, rounding, the feed-forward sum, three
// gain steps and the state update. A finished sample waits while the previous
// result has not been taken. A finished sample sits in the output register
// while the next one is accepted and computed. Coefficients are to be written
// through the configuration port only while the filter is idle; the block
// itself does not enforce this. Section states start at zero and are never
// cleared by a register write.
module cascaded_biquad_lowpass_filter
	import cbq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [SAMPLE_W-1:0]  s_tdata,   // [23:0] sample_in
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [SAMPLE_W-1:0]  m_tdata,   // [23:0] sample_out
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cmd_t    cmd;
	status_t status;

	cbq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	cbq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.sample_in  (s_tdata),
		.sample_out (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// An accepted sample is being worked on in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted twice in a row");

	// A new result never overwrites one that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("pending result overwritten");

	// Every accumulate uses a product formed in the previous cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_op != ACC_NONE) |-> $past(cmd.mul_en))
		else $error("accumulate without a fresh product");

endmodule
